/* rtl/core/flm_pkg.sv */
// Shared types, constants and opcodes for the fault latch monitor.
package flm_pkg;

  localparam int unsigned ERR_W      = 11;
  localparam int unsigned COND_W     = 7;
  localparam int unsigned DEB_N      = 5;
  localparam int unsigned DEB_W      = 3;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned STALL_W    = 6;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0]   HYST_COUNT  = 3'd5;
  localparam logic [STALL_W-1:0] STALL_LIMIT = 6'd50;

  // Error bit positions.
  localparam int unsigned B_HH_LOW  = 0;
  localparam int unsigned B_ST_LOW  = 1;
  localparam int unsigned B_MN_LOW  = 2;
  localparam int unsigned B_WT_LOW  = 3;
  localparam int unsigned B_WS_HIGH = 4;
  localparam int unsigned B_WS_FULL = 5;
  localparam int unsigned B_ADC     = 6;
  localparam int unsigned B_SWITCH  = 7;
  localparam int unsigned B_BROWN   = 8;

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_DETECT  = 4'd1,
    OP_CLEAR   = 4'd2,
    OP_SET     = 4'd3,
    OP_ARM     = 4'd4,
    OP_DISARM  = 4'd5,
    OP_ADC_NEW = 4'd6,
    OP_TAKE    = 4'd7,
    OP_INIT    = 4'd8
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HH_LOW    = 4'd0,
    CFG_HH_ACTIVE = 4'd1,
    CFG_ST_LOW    = 4'd2,
    CFG_MN_LOW    = 4'd3,
    CFG_WT_LOW    = 4'd4,
    CFG_WS_HIGH   = 4'd5,
    CFG_WS_FULL   = 4'd6,
    CFG_TIMEOUT   = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]       opcode;
    logic [ERR_W-1:0] mask;
    logic [15:0]      house_mv;
    logic [15:0]      starter_mv;
    logic [15:0]      v_mains;
    logic [7:0]       water_level;
    logic [7:0]       waste_level;
    logic             household_on;
    logic [5:0]       reset_flags;
  } in_item_t;

  typedef struct packed {
    logic [ERR_W-1:0] error_bits;
    logic [ERR_W-1:0] rising_bits;
    logic             relay_off_pulse;
  } out_item_t;

  typedef struct packed {
    logic [15:0] household_low_mv;
    logic [15:0] household_active_mv;
    logic [15:0] starter_low_mv;
    logic [15:0] mains_low_mv;
    logic [7:0]  water_low_pct;
    logic [7:0]  waste_high_pct;
    logic [7:0]  waste_full_pct;
    logic [15:0] switch_timeout_ticks;
  } cfg_t;

endpackage

/* rtl/core/flm_cfg_regs.sv */
// Threshold and timeout configuration registers.
module flm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [flm_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0]     wr_data,
  output flm_pkg::cfg_t                      cfg
);

  flm_pkg::cfg_t cfg_r;
  flm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (flm_pkg::cfg_idx_t'(wr_index))
        flm_pkg::CFG_HH_LOW:    cfg_nxt.household_low_mv     = wr_data;
        flm_pkg::CFG_HH_ACTIVE: cfg_nxt.household_active_mv  = wr_data;
        flm_pkg::CFG_ST_LOW:    cfg_nxt.starter_low_mv       = wr_data;
        flm_pkg::CFG_MN_LOW:    cfg_nxt.mains_low_mv         = wr_data;
        flm_pkg::CFG_WT_LOW:    cfg_nxt.water_low_pct        = wr_data[7:0];
        flm_pkg::CFG_WS_HIGH:   cfg_nxt.waste_high_pct       = wr_data[7:0];
        flm_pkg::CFG_WS_FULL:   cfg_nxt.waste_full_pct       = wr_data[7:0];
        flm_pkg::CFG_TIMEOUT:   cfg_nxt.switch_timeout_ticks = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.household_low_mv     <= 16'd11500;
      cfg_r.household_active_mv  <= 16'd13000;
      cfg_r.starter_low_mv       <= 16'd11000;
      cfg_r.mains_low_mv         <= 16'd11000;
      cfg_r.water_low_pct        <= 8'd25;
      cfg_r.waste_high_pct       <= 8'd75;
      cfg_r.waste_full_pct       <= 8'd100;
      cfg_r.switch_timeout_ticks <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/flm_cond.sv */
// Live fault conditions from the sample fields and the thresholds.
module flm_cond (
  input  flm_pkg::in_item_t                item,
  input  flm_pkg::cfg_t                    cfg,
  input  logic [flm_pkg::STALL_W-1:0]      stall_count,
  output logic [flm_pkg::COND_W-1:0]       cond
);

  always_comb begin
    cond = '0;
    cond[flm_pkg::B_HH_LOW]  = (item.house_mv != 16'd0) &&
                               (item.house_mv < cfg.household_low_mv);
    cond[flm_pkg::B_ST_LOW]  = (item.starter_mv != 16'd0) &&
                               (item.starter_mv < cfg.starter_low_mv);
    cond[flm_pkg::B_MN_LOW]  = item.household_on && (item.v_mains != 16'd0) &&
                               (item.v_mains < cfg.mains_low_mv);
    cond[flm_pkg::B_WT_LOW]  = item.water_level <= cfg.water_low_pct;
    cond[flm_pkg::B_WS_HIGH] = item.waste_level >= cfg.waste_high_pct;
    cond[flm_pkg::B_WS_FULL] = item.waste_level >= cfg.waste_full_pct;
    cond[flm_pkg::B_ADC]     = stall_count >= flm_pkg::STALL_LIMIT;
  end

endmodule

/* rtl/core/flm_core.sv */
// Latched error state, debounce counters and watchdog, updated once per transaction.
module flm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  flm_pkg::in_item_t   item,
  input  flm_pkg::cfg_t       cfg,
  output flm_pkg::out_item_t  result
);

  logic [flm_pkg::ERR_W-1:0]   latched_r, latched_nxt;
  logic [flm_pkg::ERR_W-1:0]   reported_r, reported_nxt;
  logic [flm_pkg::DEB_W-1:0]   deb_r [flm_pkg::DEB_N];
  logic [flm_pkg::DEB_W-1:0]   deb_nxt [flm_pkg::DEB_N];
  logic                        armed_r, armed_nxt;
  logic [flm_pkg::TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [flm_pkg::STALL_W-1:0] stall_r, stall_nxt;
  logic [flm_pkg::COND_W-1:0]  cond;
  logic [flm_pkg::ERR_W-1:0]   eff;

  flm_cond u_cond (
    .item        (item),
    .cfg         (cfg),
    .stall_count (stall_r),
    .cond        (cond)
  );

  assign eff = item.mask & ~{{(flm_pkg::ERR_W - flm_pkg::COND_W){1'b0}}, cond};

  always_comb begin
    latched_nxt  = latched_r;
    reported_nxt = reported_r;
    deb_nxt      = deb_r;
    armed_nxt    = armed_r;
    ticks_nxt    = ticks_r;
    stall_nxt    = stall_r;
    result.rising_bits     = '0;
    result.relay_off_pulse = 1'b0;

    case (flm_pkg::opcode_t'(item.opcode))
      flm_pkg::OP_TICK: begin
        if (armed_r && (ticks_r != '0)) begin
          ticks_nxt = ticks_r - 1'b1;
        end
        if (stall_r < flm_pkg::STALL_LIMIT) begin
          stall_nxt = stall_r + 1'b1;
        end
      end
      flm_pkg::OP_DETECT: begin
        for (int i = 0; i < flm_pkg::DEB_N; i++) begin
          if (cond[i]) begin
            if (deb_r[i] < flm_pkg::HYST_COUNT) begin
              deb_nxt[i] = deb_r[i] + 1'b1;
              if (deb_nxt[i] == flm_pkg::HYST_COUNT) begin
                latched_nxt[i] = 1'b1;
              end
            end
          end else begin
            deb_nxt[i] = '0;
          end
        end
        if (cond[flm_pkg::B_WS_FULL]) begin
          latched_nxt[flm_pkg::B_WS_FULL] = 1'b1;
        end
        if (armed_r) begin
          // Confirmation voltage wins over an expired count.
          if (item.house_mv > cfg.household_active_mv) begin
            armed_nxt = 1'b0;
          end else if (ticks_r == '0) begin
            result.relay_off_pulse          = 1'b1;
            latched_nxt[flm_pkg::B_SWITCH] = 1'b1;
            armed_nxt                       = 1'b0;
          end
        end
        if (cond[flm_pkg::B_ADC]) begin
          latched_nxt[flm_pkg::B_ADC] = 1'b1;
        end
      end
      flm_pkg::OP_CLEAR: begin
        latched_nxt  = latched_r & ~eff;
        reported_nxt = reported_r & ~eff;
      end
      flm_pkg::OP_SET: begin
        latched_nxt = latched_r | item.mask;
      end
      flm_pkg::OP_ARM: begin
        armed_nxt = 1'b1;
        ticks_nxt = cfg.switch_timeout_ticks;
      end
      flm_pkg::OP_DISARM: begin
        armed_nxt = 1'b0;
      end
      flm_pkg::OP_ADC_NEW: begin
        stall_nxt = '0;
      end
      flm_pkg::OP_TAKE: begin
        result.rising_bits = latched_r & ~reported_r;
        reported_nxt       = latched_r;
      end
      flm_pkg::OP_INIT: begin
        latched_nxt  = '0;
        reported_nxt = '0;
        for (int i = 0; i < flm_pkg::DEB_N; i++) begin
          deb_nxt[i] = '0;
        end
        armed_nxt = 1'b0;
        ticks_nxt = '0;
        stall_nxt = '0;
        if (!item.reset_flags[0]) begin
          latched_nxt[flm_pkg::B_BROWN] = 1'b1;
        end
      end
      default: ;
    endcase

    result.error_bits = latched_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r  <= '0;
      reported_r <= '0;
      for (int i = 0; i < flm_pkg::DEB_N; i++) begin
        deb_r[i] <= '0;
      end
      armed_r <= 1'b0;
      ticks_r <= '0;
      stall_r <= '0;
    end else if (step) begin
      latched_r  <= latched_nxt;
      reported_r <= reported_nxt;
      deb_r      <= deb_nxt;
      armed_r    <= armed_nxt;
      ticks_r    <= ticks_nxt;
      stall_r    <= stall_nxt;
    end
  end

endmodule

/* rtl/core/fault_latch_monitor_core.sv */
// An accepted transaction is held in the input register, then its result is offered
// from the result register. Throughput: one transaction per cycle unless out_ready
// stalls; each item's state update is a single pass through the condition compares
// and flag logic between input and result registers. Reset (synchronous, active low)
// clears error words, counters and watchdog and loads threshold register defaults.
module fault_latch_monitor_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  flm_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output flm_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [flm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [flm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                in_valid_r;
  flm_pkg::in_item_t   in_item_r;
  logic                out_valid_r;
  flm_pkg::out_item_t  out_item_r;
  flm_pkg::cfg_t       cfg;
  flm_pkg::out_item_t  result;
  logic                advance;

  // The held item moves on whenever the result register is empty or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  flm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  flm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* bench/fault_latch_monitor_checker.sv */
// Status predictor and comparator that watches the fault latch monitor's three channels.
`timescale 1ns / 1ps

module fault_latch_monitor_checker
  import flm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           pending,
  output int unsigned           mismatches,
  output cfg_t                  thr_now
);

  localparam cfg_t RESET_THR = {16'd11500, 16'd13000, 16'd11000, 16'd11000,
                                8'd25, 8'd75, 8'd100, 16'd300};

  cfg_t               thr;
  logic [ERR_W-1:0]   fault_word;
  logic [ERR_W-1:0]   reported_word;
  logic [DEB_W-1:0]   deb_cnt [DEB_N];
  logic               wd_armed;
  logic [TICK_W-1:0]  wd_ticks;
  logic [STALL_W-1:0] stall_cnt;
  out_item_t          status_q [$];
  int unsigned        mismatch_cnt = 0;

  function automatic void clear_fault_state();
    int i;
    fault_word    = '0;
    reported_word = '0;
    for (i = 0; i < DEB_N; i++) deb_cnt[i] = '0;
    wd_armed  = 1'b0;
    wd_ticks  = '0;
    stall_cnt = '0;
  endfunction

  // Conditions as they stand for this sample; a zero voltage means no reading.
  function automatic logic [COND_W-1:0] live_faults(input in_item_t it);
    logic [COND_W-1:0] c;
    c = '0;
    c[B_HH_LOW]  = it.house_mv != 0 && it.house_mv < thr.household_low_mv;
    c[B_ST_LOW]  = it.starter_mv != 0 && it.starter_mv < thr.starter_low_mv;
    c[B_MN_LOW]  = it.household_on && it.v_mains != 0 && it.v_mains < thr.mains_low_mv;
    c[B_WT_LOW]  = it.water_level <= thr.water_low_pct;
    c[B_WS_HIGH] = it.waste_level >= thr.waste_high_pct;
    c[B_WS_FULL] = it.waste_level >= thr.waste_full_pct;
    c[B_ADC]     = stall_cnt >= STALL_LIMIT;
    return c;
  endfunction

  function automatic out_item_t expected_status(input in_item_t it);
    logic [COND_W-1:0] live;
    logic [ERR_W-1:0]  eff;
    logic [ERR_W-1:0]  rising;
    logic              pulse;
    out_item_t         res;
    int                i;
    live   = live_faults(it);
    rising = '0;
    pulse  = 1'b0;
    case (opcode_t'(it.opcode))
      OP_TICK: begin
        if (wd_armed && wd_ticks != '0) wd_ticks = wd_ticks - 1'b1;
        if (stall_cnt < STALL_LIMIT) stall_cnt = stall_cnt + 1'b1;
      end
      OP_DETECT: begin
        for (i = 0; i < DEB_N; i++) begin
          if (live[i]) begin
            if (deb_cnt[i] < HYST_COUNT) begin
              deb_cnt[i] = deb_cnt[i] + 1'b1;
              if (deb_cnt[i] == HYST_COUNT) fault_word[i] = 1'b1;
            end
          end else begin
            deb_cnt[i] = '0;
          end
        end
        if (live[B_WS_FULL]) fault_word[B_WS_FULL] = 1'b1;
        if (wd_armed) begin
          if (it.house_mv > thr.household_active_mv) begin
            wd_armed = 1'b0;
          end else if (wd_ticks == '0) begin
            pulse                = 1'b1;
            fault_word[B_SWITCH] = 1'b1;
            wd_armed             = 1'b0;
          end
        end
        if (live[B_ADC]) fault_word[B_ADC] = 1'b1;
      end
      OP_CLEAR: begin
        // Bits whose condition still holds cannot be cleared.
        eff           = it.mask & ~{{(ERR_W - COND_W){1'b0}}, live};
        fault_word    = fault_word & ~eff;
        reported_word = reported_word & ~eff;
      end
      OP_SET:     fault_word = fault_word | it.mask;
      OP_ARM: begin
        wd_armed = 1'b1;
        wd_ticks = thr.switch_timeout_ticks;
      end
      OP_DISARM:  wd_armed = 1'b0;
      OP_ADC_NEW: stall_cnt = '0;
      OP_TAKE: begin
        rising        = fault_word & ~reported_word;
        reported_word = fault_word;
      end
      OP_INIT: begin
        clear_fault_state();
        if (!it.reset_flags[0]) fault_word[B_BROWN] = 1'b1;
      end
      default: ;
    endcase
    res.error_bits      = fault_word;
    res.rising_bits     = rising;
    res.relay_off_pulse = pulse;
    return res;
  endfunction

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      thr = RESET_THR;
      clear_fault_state();
      status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: unexpected status transaction: expected none, got %h",
                   $time, out_item);
          mismatch_cnt++;
        end else begin
          want = status_q.pop_front();
          if (out_item.error_bits !== want.error_bits ||
              out_item.rising_bits !== want.rising_bits ||
              out_item.relay_off_pulse !== want.relay_off_pulse) begin
            $display("%0t: mismatch: exp err=%h rise=%h off=%b, got err=%h rise=%h off=%b",
                     $time, want.error_bits, want.rising_bits, want.relay_off_pulse,
                     out_item.error_bits, out_item.rising_bits, out_item.relay_off_pulse);
            mismatch_cnt++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HH_LOW:    thr.household_low_mv     = cfg_data;
          CFG_HH_ACTIVE: thr.household_active_mv  = cfg_data;
          CFG_ST_LOW:    thr.starter_low_mv       = cfg_data;
          CFG_MN_LOW:    thr.mains_low_mv         = cfg_data;
          CFG_WT_LOW:    thr.water_low_pct        = cfg_data[7:0];
          CFG_WS_HIGH:   thr.waste_high_pct       = cfg_data[7:0];
          CFG_WS_FULL:   thr.waste_full_pct       = cfg_data[7:0];
          CFG_TIMEOUT:   thr.switch_timeout_ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) status_q.push_back(expected_status(in_item));
    end
    pending    <= status_q.size();
    mismatches <= mismatch_cnt;
    thr_now    <= thr;
  end

endmodule

/* bench/fault_latch_monitor_core_tb.sv */
// Stimulus, handshake pacing and verdict for the fault latch monitor core.
`timescale 1ns / 1ps

module fault_latch_monitor_core_tb;
  import flm_pkg::*;

  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned OP_TOP          = 2 ** $bits(opcode_t) - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int unsigned pending;
  int unsigned mismatches;
  cfg_t        thr_now;
  int unsigned idle_cycles = 0;
  bit          burst       = 1'b0;
  bit          quiet_adc   = 1'b0;
  bit          hold_req    = 1'b0;
  in_item_t    env         = '0;

  always #2 clk = ~clk;

  fault_latch_monitor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fault_latch_monitor_checker status_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches),
    .thr_now    (thr_now)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a fresh stall before each transaction, or one long hold when asked.
  initial begin : receiver
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = burst ? 0 : $urandom_range(0, 19);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every predicted status has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // The byte-wide registers get junk in the upper byte, which must be dropped.
  task automatic load_thresholds(input cfg_t c);
    put_reg(CFG_HH_LOW, c.household_low_mv);
    put_reg(CFG_HH_ACTIVE, c.household_active_mv);
    put_reg(CFG_ST_LOW, c.starter_low_mv);
    put_reg(CFG_MN_LOW, c.mains_low_mv);
    put_reg(CFG_WT_LOW, {8'($urandom), c.water_low_pct});
    put_reg(CFG_WS_HIGH, {8'($urandom), c.waste_high_pct});
    put_reg(CFG_WS_FULL, {8'($urandom), c.waste_full_pct});
    put_reg(CFG_TIMEOUT, c.switch_timeout_ticks);
    put_reg(CFG_IDX_W'($urandom_range(int'(CFG_TIMEOUT) + 1, 2 ** CFG_IDX_W - 1)),
            CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t random_thresholds();
    cfg_t c;
    c.household_low_mv     = 16'($urandom_range(10000, 13000));
    c.household_active_mv  = 16'($urandom_range(12000, 15000));
    c.starter_low_mv       = 16'($urandom_range(10000, 12000));
    c.mains_low_mv         = 16'($urandom_range(10000, 12000));
    c.water_low_pct        = 8'($urandom);
    c.waste_high_pct       = 8'($urandom);
    c.waste_full_pct       = 8'($urandom);
    c.switch_timeout_ticks = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 12));
    return c;
  endfunction

  // Mostly close to a threshold so that conditions flip, sometimes at the rails.
  function automatic logic [15:0] near_level(input int unsigned mark, input int unsigned top_val);
    int unsigned v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = top_val;
      2: v = $urandom_range(0, top_val);
      default: begin
        v = mark + $urandom_range(0, 4);
        v = (v >= 2) ? v - 2 : 0;
        if (v > top_val) v = top_val;
      end
    endcase
    return v[15:0];
  endfunction

  // Sensor readings stay put for a while so that debounce runs can build up.
  function automatic void drift_sensors();
    if ($urandom_range(0, 9) == 0)
      env.house_mv = near_level($urandom_range(0, 1) ? thr_now.household_low_mv
                                                     : thr_now.household_active_mv, 16'hFFFF);
    if ($urandom_range(0, 9) == 0) env.starter_mv = near_level(thr_now.starter_low_mv, 16'hFFFF);
    if ($urandom_range(0, 9) == 0) env.v_mains = near_level(thr_now.mains_low_mv, 16'hFFFF);
    if ($urandom_range(0, 9) == 0) env.water_level = 8'(near_level(thr_now.water_low_pct, 255));
    if ($urandom_range(0, 9) == 0)
      env.waste_level = 8'(near_level($urandom_range(0, 1) ? thr_now.waste_high_pct
                                                           : thr_now.waste_full_pct, 255));
    if ($urandom_range(0, 9) == 0) env.household_on = 1'($urandom);
  endfunction

  function automatic in_item_t make_item(input logic [3:0] op, input logic [ERR_W-1:0] mask,
                                         input logic [5:0] flags);
    in_item_t it;
    it             = env;
    it.opcode      = op;
    it.mask        = mask;
    it.reset_flags = flags;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int unsigned r;
    logic [3:0]  op;
    r = $urandom_range(0, 99);
    if (r < 30)      op = OP_DETECT;
    else if (r < 55) op = OP_TICK;
    else if (r < 62) op = OP_CLEAR;
    else if (r < 66) op = OP_SET;
    else if (r < 72) op = OP_ARM;
    else if (r < 75) op = OP_DISARM;
    else if (r < 78) op = quiet_adc ? OP_TICK : OP_ADC_NEW;
    else if (r < 86) op = OP_TAKE;
    else if (r < 88) op = OP_INIT;
    else             op = 4'($urandom_range(int'(OP_INIT) + 1, OP_TOP));
    return make_item(op, ($urandom_range(0, 7) == 0) ? '1 : ERR_W'($urandom), 6'($urandom));
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned k;
    cfg_t        c;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset thresholds, with no readings and an empty water tank.
    env              = '0;
    env.household_on = 1'b1;
    send_item(make_item(OP_INIT, '0, 6'h3E));
    send_item(make_item(OP_TAKE, '0, '0));
    send_item(make_item(OP_INIT, '0, 6'h3F));
    send_item(make_item(OP_SET, '1, '0));
    send_item(make_item('1, '0, '0));
    send_item(make_item(OP_CLEAR, '1, '0));
    send_item(make_item(OP_TAKE, '0, '0));
    send_item(make_item(OP_INIT, '1, 6'h3F));
    // Every condition but the ADC stall true: the debounced bits latch on the fifth detect and then hold.
    env = '{opcode: '0, mask: '0, house_mv: 16'd1, starter_mv: 16'd1, v_mains: 16'd1,
            water_level: 8'd0, waste_level: 8'hFF, household_on: 1'b1, reset_flags: '0};
    repeat (6) send_item(make_item(OP_DETECT, '0, '0));
    send_item(make_item(OP_CLEAR, '1, '0));
    env = '{opcode: '0, mask: '0, house_mv: 16'hFFFF, starter_mv: 16'hFFFF,
            v_mains: 16'hFFFF, water_level: 8'hFF, waste_level: 8'd0, household_on: 1'b0,
            reset_flags: '1};
    send_item(make_item(OP_DETECT, '0, '0));
    send_item(make_item(OP_CLEAR, '1, '0));
    send_item(make_item(OP_ARM, '0, '0));
    send_item(make_item(OP_DETECT, '0, '0));
    send_item(make_item(OP_ARM, '0, '0));
    send_item(make_item(OP_TICK, '0, '0));
    send_item(make_item(OP_DISARM, '0, '0));
    send_item(make_item(OP_ADC_NEW, '0, '0));
    send_item(make_item(OP_TAKE, '0, '0));
    send_item(make_item(4'(int'(OP_INIT) + 1), '1, '1));

    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        1:       c = '0;
        2:       c = '1;
        default: c = random_thresholds();
      endcase
      load_thresholds(c);
      @(posedge clk);
      burst     = (phase == 1 || phase == 5);
      quiet_adc = (phase == 1 || phase == 3 || phase == 6);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 2 && k == 20) hold_req = 1'b1;
        if (phase == 4 && k == 60) drain();
        drift_sensors();
        send_item(random_item());
      end
    end

    burst = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
